### design/utf8d_pkg.sv
// utf8d_pkg: shared widths, types and decode helpers of the utf-8 code point decoder
// no dependencies; used by the interfaces and every module of the decoder

package utf8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   code_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // follower bytes wanted by a lead
    localparam cnt_t LEAD_NONE  = 2'd0;
    localparam cnt_t LEAD_TWO   = 2'd1;
    localparam cnt_t LEAD_THREE = 2'd2;
    localparam cnt_t LEAD_FOUR  = 2'd3;

    typedef struct packed {
        logic  valid;
        byte_t data;
        logic  last;
    } in_item_t;

    typedef struct packed {
        cnt_t                   n;
        code_t [MAX_RES-1:0]    cp;
        logic                   eos;
    } res_bundle_t;

    function automatic cnt_t lead_class(byte_t c);
        cnt_t k;
        k = LEAD_NONE;
        if ((c & 8'he0) == 8'hc0)
        begin
            k = LEAD_TWO;
        end
        else if ((c & 8'hf0) == 8'he0)
        begin
            k = LEAD_THREE;
        end
        else if ((c & 8'hf8) == 8'hf0)
        begin
            k = LEAD_FOUR;
        end
        return k;
    endfunction

    function automatic code_t assemble(byte_t lead, byte_t f0, byte_t f1, byte_t f2, cnt_t k);
        code_t v;
        unique case (k)
            LEAD_TWO:   v = CP_W'({lead[4:0], f0[5:0]});
            LEAD_THREE: v = CP_W'({lead[3:0], f0[5:0], f1[5:0]});
            LEAD_FOUR:  v = {lead[2:0], f0[5:0], f1[5:0], f2[5:0]};
            default:    v = CP_W'(lead);
        endcase
        return v;
    endfunction

endpackage

### design/utf8d_byte_if.sv
// utf8d_byte_if: valid/ready channel carrying one string byte per request
// depends on utf8d_pkg

interface utf8d_byte_if;
    logic               valid;
    logic               ready;
    utf8d_pkg::byte_t   byte_in;
    logic               last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

### design/utf8d_cp_if.sv
// utf8d_cp_if: valid/ready channel carrying one decoded code point per request
// depends on utf8d_pkg

interface utf8d_cp_if;
    logic               valid;
    logic               ready;
    utf8d_pkg::code_t   code_point;
    logic               end_of_string;

    modport source (output valid, output code_point, output end_of_string, input ready);
    modport sink   (input valid, input code_point, input end_of_string, output ready);
endinterface

### design/utf8d_in_stage.sv
// utf8d_in_stage: input register for incoming byte requests
// depends on utf8d_pkg and utf8d_byte_if

module utf8d_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    utf8d_byte_if.sink          byte_ch,
    input  logic                advance,
    output utf8d_pkg::in_item_t item
);
    import utf8d_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    byte_t data_reg;
    logic  last_reg;
    logic  take;

    assign byte_ch.ready = !valid_reg || advance;
    assign take          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= byte_ch.byte_in;
            last_reg <= byte_ch.last_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.last  = last_reg;

endmodule

### design/utf8d_core.sv
// utf8d_core: pending sequence state, assembly and end-of-string flush
// depends on utf8d_pkg

module utf8d_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8d_pkg::in_item_t     item,
    input  logic                    advance,
    output utf8d_pkg::res_bundle_t  bundle
);
    import utf8d_pkg::*;

    byte_t pend_reg [MAX_RES];
    byte_t pend_next [MAX_RES];
    cnt_t  pc_reg;
    cnt_t  pc_next;
    cnt_t  bn_reg;
    cnt_t  bn_next;
    cnt_t  pc_mid;
    cnt_t  bn_mid;
    cnt_t  k_in;
    logic  prim_valid;
    code_t prim_cp;
    byte_t f0;
    byte_t f1;
    code_t fl_cp [MAX_RES];
    cnt_t  fl_n;

    assign k_in = lead_class(item.data);

    // sequence state update
    always_comb
    begin
        pend_next  = pend_reg;
        pc_mid     = pc_reg;
        bn_mid     = bn_reg;
        prim_valid = 1'b0;
        prim_cp    = '0;
        f0         = (bn_reg == LEAD_TWO) ? item.data : pend_reg[1];
        f1         = (bn_reg == LEAD_THREE) ? item.data : pend_reg[2];
        if (pc_reg == 2'd0)
        begin
            if (k_in == LEAD_NONE)
            begin
                prim_valid = 1'b1;
                prim_cp    = CP_W'(item.data);
            end
            else
            begin
                pend_next[0] = item.data;
                pc_mid       = 2'd1;
                bn_mid       = k_in;
            end
        end
        else if (pc_reg >= bn_reg)
        begin
            prim_valid = 1'b1;
            prim_cp    = assemble(pend_reg[0], f0, f1, item.data, bn_reg);
            pc_mid     = 2'd0;
            bn_mid     = LEAD_NONE;
        end
        else
        begin
            if (pc_reg == 2'd1)
            begin
                pend_next[1] = item.data;
            end
            else
            begin
                pend_next[2] = item.data;
            end
            pc_mid = pc_reg + 2'd1;
        end
    end

    // flush of an unfinished sequence
    always_comb
    begin
        fl_cp[0] = CP_W'(pend_next[0]);
        fl_cp[1] = CP_W'(pend_next[1]);
        fl_cp[2] = CP_W'(pend_next[2]);
        fl_n     = pc_mid;
        if (pc_mid == 2'd3 && lead_class(pend_next[1]) == LEAD_TWO)
        begin
            fl_cp[1] = assemble(pend_next[1], pend_next[2], '0, '0, LEAD_TWO);
            fl_cp[2] = '0;
            fl_n     = 2'd2;
        end
    end

    always_comb
    begin
        bundle.eos = item.last;
        if (item.last && pc_mid != 2'd0)
        begin
            bundle.n     = fl_n;
            bundle.cp[0] = fl_cp[0];
            bundle.cp[1] = fl_cp[1];
            bundle.cp[2] = fl_cp[2];
        end
        else
        begin
            bundle.n     = cnt_t'(prim_valid);
            bundle.cp[0] = prim_cp;
            bundle.cp[1] = '0;
            bundle.cp[2] = '0;
        end
        if (!advance)
        begin
            bundle.n = 2'd0;
        end
    end

    always_comb
    begin
        pc_next = pc_reg;
        bn_next = bn_reg;
        if (advance)
        begin
            pc_next = item.last ? 2'd0 : pc_mid;
            bn_next = item.last ? LEAD_NONE : bn_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 2'd0;
            bn_reg <= LEAD_NONE;
        end
        else
        begin
            pc_reg <= pc_next;
            bn_reg <= bn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

### design/utf8d_out_queue.sv
// utf8d_out_queue: result register holding up to three code points, sent one per request
// depends on utf8d_pkg and utf8d_cp_if

module utf8d_out_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8d_pkg::res_bundle_t  bundle,
    output logic                    free,
    utf8d_cp_if.source              cp_ch
);
    import utf8d_pkg::*;

    cnt_t  rem_reg;
    cnt_t  rem_next;
    code_t cp_reg [MAX_RES];
    logic  eos_reg;
    logic  pop;
    logic  load;

    assign pop  = cp_ch.valid && cp_ch.ready;
    assign free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && cp_ch.ready);
    assign load = bundle.n != 2'd0;

    always_comb
    begin
        rem_next = rem_reg;
        if (load)
        begin
            rem_next = bundle.n;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg[0] <= bundle.cp[0];
            cp_reg[1] <= bundle.cp[1];
            cp_reg[2] <= bundle.cp[2];
            eos_reg   <= bundle.eos;
        end
        else if (pop)
        begin
            cp_reg[0] <= cp_reg[1];
            cp_reg[1] <= cp_reg[2];
        end
    end

    assign cp_ch.valid         = rem_reg != 2'd0;
    assign cp_ch.code_point    = cp_reg[0];
    assign cp_ch.end_of_string = eos_reg && rem_reg == 2'd1;

endmodule

### design/utf8_code_point_decoder.sv
// utf8_code_point_decoder: top level, byte stream in, code points out
// depends on utf8d_pkg, utf8d_byte_if, utf8d_cp_if, utf8d_in_stage, utf8d_core, utf8d_out_queue
//
//   channel  | dir | payload                      | accepted when
//   byte_ch  | in  | byte_in[7:0], last_byte      | valid && ready
//   cp_ch    | out | code_point[20:0], end_of_str | valid && ready
//
// one byte is taken per cycle unless stalled; the input register feeds the result register
// a byte giving n results holds the result register until all n are sent (n up to 3 on a flush)
// the byte path stalls only while the result register still holds more than one code point
// or its last one is not taken
// rst_n clears the pending count, lead class and all valid flags; byte storage is not reset

module utf8_code_point_decoder (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  byte_ch,
    utf8d_cp_if.source  cp_ch
);
    import utf8d_pkg::*;

    in_item_t    item;
    res_bundle_t bundle;
    logic        free;
    logic        advance;

    assign advance = item.valid && free;

    utf8d_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .advance (advance),
        .item    (item)
    );

    utf8d_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .bundle  (bundle)
    );

    utf8d_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .bundle (bundle),
        .free   (free),
        .cp_ch  (cp_ch)
    );

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last |-> bundle.n != 2'd0)
        else $error("string end produced no result");

    a_result_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.n != 2'd0 |-> advance)
        else $error("result produced without a byte moving on");

    a_idle_output_takes_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        !cp_ch.valid |-> byte_ch.ready)
        else $error("byte path stalled with empty result register");
`endif

endmodule

### tb/utf8_decode_checker.sv
`timescale 1ns / 1ps
// utf8_decode_checker: watches the byte and code point channels of the decoder,
// predicts the code points of every accepted byte and compares them in order
// depends on utf8d_pkg, utf8d_byte_if and utf8d_cp_if

module utf8_decode_checker (
    input  logic    clk,
    input  logic    rst_n,
    utf8d_byte_if   byte_ch,
    utf8d_cp_if     cp_ch,
    output int      mismatch_count,
    output int      waiting_count
);
    import utf8d_pkg::*;

    typedef struct {
        code_t cp;
        logic  eos;
    } code_rec_t;

    code_rec_t expected_cps[$];
    code_rec_t oldest_cp;
    byte_t     held[3];
    int        held_count;
    int        follow_need;

    function automatic int follower_count(byte_t c);
        int k;
        k = 0;
        if (c[7:5] == 3'b110)
        begin
            k = 1;
        end
        else if (c[7:4] == 4'b1110)
        begin
            k = 2;
        end
        else if (c[7:3] == 5'b11110)
        begin
            k = 3;
        end
        return k;
    endfunction

    function automatic code_t pack_code(byte_t lead, byte_t f0, byte_t f1, byte_t f2, int k);
        code_t v;
        if (k == 1)
        begin
            v = code_t'({lead[4:0], f0[5:0]});
        end
        else if (k == 2)
        begin
            v = code_t'({lead[3:0], f0[5:0], f1[5:0]});
        end
        else
        begin
            v = {lead[2:0], f0[5:0], f1[5:0], f2[5:0]};
        end
        return v;
    endfunction

    task automatic predict_code_points(input byte_t b, input logic fin);
        code_rec_t res[$];
        int        k;
        int        i;
        if (held_count == 0)
        begin
            k = follower_count(b);
            if (k == 0)
            begin
                res.push_back('{code_t'(b), 1'b0});
            end
            else
            begin
                held[0] = b;
                held_count = 1;
                follow_need = k;
            end
        end
        else if (held_count >= follow_need)
        begin
            if (follow_need == 1)
            begin
                res.push_back('{pack_code(held[0], b, 8'h00, 8'h00, 1), 1'b0});
            end
            else if (follow_need == 2)
            begin
                res.push_back('{pack_code(held[0], held[1], b, 8'h00, 2), 1'b0});
            end
            else
            begin
                res.push_back('{pack_code(held[0], held[1], held[2], b, 3), 1'b0});
            end
            held_count = 0;
            follow_need = 0;
        end
        else
        begin
            held[held_count] = b;
            held_count++;
        end
        if (fin)
        begin
            if (held_count > 0)
            begin
                // lead goes out raw, the tail is decoded again as a closed string
                res.push_back('{code_t'(held[0]), 1'b0});
                i = 1;
                while (i < held_count)
                begin
                    k = follower_count(held[i]);
                    if (k > 0 && i + k < held_count)
                    begin
                        // only a two-byte sequence fits in the flushed tail
                        res.push_back('{pack_code(held[i], held[i+1], 8'h00, 8'h00, k), 1'b0});
                        i = i + k + 1;
                    end
                    else
                    begin
                        res.push_back('{code_t'(held[i]), 1'b0});
                        i++;
                    end
                end
            end
            held_count = 0;
            follow_need = 0;
            if (res.size() > 0)
            begin
                res[res.size()-1].eos = 1'b1;
            end
        end
        foreach (res[j])
        begin
            expected_cps.push_back(res[j]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_cps.delete();
            held_count = 0;
            follow_need = 0;
            mismatch_count = 0;
            waiting_count = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_code_points(byte_ch.byte_in, byte_ch.last_byte);
            end
            if (cp_ch.valid && cp_ch.ready)
            begin
                if (expected_cps.size() == 0)
                begin
                    $display("%0t: unexpected code point %h end %b", $time,
                             cp_ch.code_point, cp_ch.end_of_string);
                    mismatch_count++;
                end
                else
                begin
                    oldest_cp = expected_cps.pop_front();
                    if (cp_ch.code_point !== oldest_cp.cp)
                    begin
                        $display("%0t: code_point expected %h actual %h", $time,
                                 oldest_cp.cp, cp_ch.code_point);
                        mismatch_count++;
                    end
                    if (cp_ch.end_of_string !== oldest_cp.eos)
                    begin
                        $display("%0t: end_of_string expected %b actual %b", $time,
                                 oldest_cp.eos, cp_ch.end_of_string);
                        mismatch_count++;
                    end
                end
            end
            waiting_count = expected_cps.size();
        end
    end

endmodule

### tb/tb_utf8_code_point_decoder.sv
`timescale 1ns / 1ps
// tb_utf8_code_point_decoder: drives directed and random byte strings into the decoder
// under several idle and stall mixes, and reports the checker's verdict
// depends on utf8d_pkg, the channel interfaces, utf8_code_point_decoder, utf8_decode_checker

module tb_utf8_code_point_decoder;

    import utf8d_pkg::*;

    localparam int ITEMS_PER_PHASE = 84;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   sent_count;
    int   mismatch_count;
    int   waiting_count;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_code_point_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cp_ch   (cp_ch)
    );

    utf8_decode_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_ch        (byte_ch),
        .cp_ch          (cp_ch),
        .mismatch_count (mismatch_count),
        .waiting_count  (waiting_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_byte(input byte_t b, input logic fin);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.byte_in   <= b;
        byte_ch.last_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_string(input byte_t s[$]);
        foreach (s[i])
        begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    function automatic void add_char(ref byte_t s[$]);
        int len;
        len = $urandom_range(1, 4);
        case (len)
            1: s.push_back(byte_t'($urandom_range(1, 127)));
            2: s.push_back({3'b110, 5'($urandom)});
            3: s.push_back({4'b1110, 4'($urandom)});
            default: s.push_back({5'b11110, 3'($urandom)});
        endcase
        repeat (len - 1)
        begin
            s.push_back({2'b10, 6'($urandom)});
        end
    endfunction

    task automatic send_random_string();
        byte_t s[$];
        int    mode;
        mode = $urandom_range(0, 99);
        if (mode < 85)
        begin
            repeat ($urandom_range(1, 5))
            begin
                add_char(s);
            end
            // broken sequences: cut short or one byte replaced
            if (mode >= 65)
            begin
                if ($urandom_range(0, 1) == 1 && s.size() > 1)
                begin
                    void'(s.pop_back());
                end
                else
                begin
                    s[$urandom_range(0, s.size() - 1)] = byte_t'($urandom_range(1, 255));
                end
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                s.push_back(byte_t'($urandom_range(1, 255)));
            end
        end
        send_string(s);
    endtask

    task automatic run_phase(input int idle, input int stall);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target = sent_count + ITEMS_PER_PHASE;
        while (sent_count < target)
        begin
            send_random_string();
        end
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.byte_in   = '0;
        byte_ch.last_byte = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        sent_count        = 0;
        repeat (11)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);

        // ascii and two-byte extremes
        send_string('{8'h01, 8'h7f, 8'hdf, 8'hbf});
        // three- and four-byte extremes
        send_string('{8'hef, 8'hbf, 8'hbf, 8'hf7, 8'hbf, 8'hbf, 8'hbf});
        // stray continuation, invalid lead, unchecked continuation mark
        send_string('{8'h80, 8'hff, 8'hc3, 8'h41});
        // unfinished sequences flushed at the string end
        send_string('{8'hc3});
        send_string('{8'he2, 8'h82});
        send_string('{8'hf0, 8'hc3, 8'ha9});
        send_string('{8'hf0, 8'he0, 8'h80});
        // zero byte alone and as a follower
        send_string('{8'h00, 8'hc3, 8'h00});

        run_phase(0, 0);
        run_phase(86, 0);
        run_phase(0, 86);
        run_phase(13, 13);
        byte_ch.valid <= 1'b0;

        while (waiting_count != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(negedge clk);
        end
        if (mismatch_count == 0 && waiting_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
design/utf8d_pkg.sv
design/utf8d_byte_if.sv
design/utf8d_cp_if.sv
design/utf8d_in_stage.sv
design/utf8d_core.sv
design/utf8d_out_queue.sv
design/utf8_code_point_decoder.sv
tb/utf8_decode_checker.sv
tb/tb_utf8_code_point_decoder.sv
